[design/rcst_pkg.sv]
// ----------------------------------------------------------------------------
// rcst_pkg
// Types, codes and default sizes shared by the reference-counted slot table.
// ----------------------------------------------------------------------------
package rcst_pkg;

	// default sizes of the table
	localparam int SLOTS_DEF       = 256;
	localparam int DATA_WIDTH_DEF  = 32;
	localparam int COUNT_WIDTH_DEF = 16;

	// fixed widths of the word fields
	localparam int MODE_W  = 2;
	localparam int SLOT_W  = 8;
	localparam int WORD_W  = 32;
	localparam int COUNT_W = 16;
	localparam int STAT_W  = 2;

	// request modes
	localparam logic [MODE_W-1:0] MODE_SET     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RETAIN  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd1;
	localparam logic [STAT_W-1:0] STAT_SATURATED = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [SLOT_W-1:0] slot;
		logic [WORD_W-1:0] entry_data;
	} req_word_t;

	typedef struct packed {
		logic               found;
		logic [WORD_W-1:0]  word_out;
		logic [COUNT_W-1:0] count_after;
		logic               discarded_new;
		logic               freed;
		logic [STAT_W-1:0]  status;
	} rsp_word_t;

endpackage

[design/refcount_slot_table.sv]
// a request and its memory read data are registered in stage 1, then its result word goes into the output register
// throughput: one request per cycle while req_stall is low; a same-slot request right behind another is forwarded
// the count memory is read when a request is accepted and written back when it leaves stage 1 (read-modify-write)
// reset: a clearing pass zeroes every slot of the count memory while req_stall is held high
// the word memory is not cleared; a word is only used while its count is nonzero
// ----------------------------------------------------------------------------
// refcount_slot_table
// Table of slots holding a data word and a reference count, with set, retain
// and release requests, each giving one result word.
// ----------------------------------------------------------------------------
module refcount_slot_table #(
	parameter int SLOTS       = rcst_pkg::SLOTS_DEF,
	parameter int DATA_WIDTH  = rcst_pkg::DATA_WIDTH_DEF,
	parameter int COUNT_WIDTH = rcst_pkg::COUNT_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  rcst_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output rcst_pkg::rsp_word_t rsp
);

	localparam int IW = $clog2(SLOTS);
	localparam int SW = IW + rcst_pkg::SLOT_W;

	typedef logic [DATA_WIDTH-1:0]  data_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;

	// storage
	count_t cnt_mem [SLOTS];
	data_t  word_mem [SLOTS];

	// clearing pass
	logic          clearing_q;
	logic [IW-1:0] clr_q;

	// stage 1: request plus memory read data
	logic                s1_valid_q;
	rcst_pkg::req_word_t req_s1;
	count_t              cnt_rd_s1;
	data_t               word_rd_s1;
	logic                fwd_s1;
	count_t              fwd_cnt_s1;
	data_t               fwd_word_s1;

	// output register
	logic                rsp_valid_q;
	rcst_pkg::rsp_word_t rsp_q;

	logic                accept;
	logic                advance;
	logic [SW-1:0]       req_slot_ext;
	logic [SW-1:0]       s1_slot_ext;
	logic                in_range_s1;
	logic [DATA_WIDTH+rcst_pkg::WORD_W-1:0]  din_ext;
	data_t               din;
	count_t              cur_cnt;
	data_t               cur_word;
	logic                empty;
	logic                at_max;
	count_t              new_cnt;
	data_t               new_word;
	logic                cnt_we;
	logic                word_we;
	rcst_pkg::rsp_word_t rsp_d;
	logic                found_d;
	data_t               wout_d;
	logic                disc_d;
	logic                freed_d;
	logic [rcst_pkg::STAT_W-1:0] status_d;
	logic [DATA_WIDTH+rcst_pkg::WORD_W-1:0]    wout_ext;
	logic [COUNT_WIDTH+rcst_pkg::COUNT_W-1:0]  cnt_ext;

	assign advance   = s1_valid_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall = clearing_q || (s1_valid_q && !advance);
	assign accept    = req_valid && !req_stall;

	assign req_slot_ext = SW'(req.slot);
	assign s1_slot_ext  = SW'(req_s1.slot);
	assign in_range_s1  = s1_slot_ext < SW'(SLOTS);

	assign din_ext = (DATA_WIDTH + rcst_pkg::WORD_W)'(req_s1.entry_data);
	assign din     = din_ext[DATA_WIDTH-1:0];

	// a request accepted while the one ahead writes the same slot takes the forwarded value
	assign cur_cnt  = fwd_s1 ? fwd_cnt_s1 : cnt_rd_s1;
	assign cur_word = fwd_s1 ? fwd_word_s1 : word_rd_s1;
	assign empty    = (cur_cnt == '0);
	assign at_max   = &cur_cnt;

	always_comb begin
		new_cnt  = cur_cnt;
		new_word = cur_word;
		found_d  = 1'b0;
		wout_d   = '0;
		disc_d   = 1'b0;
		freed_d  = 1'b0;
		status_d = rcst_pkg::STAT_OK;
		word_we  = 1'b0;
		case (req_s1.mode)
			rcst_pkg::MODE_SET: begin
				found_d = 1'b1;
				if (empty) begin
					new_cnt  = COUNT_WIDTH'(1);
					new_word = din;
					word_we  = 1'b1;
				end else begin
					disc_d = 1'b1;
					if (at_max) begin
						status_d = rcst_pkg::STAT_SATURATED;
					end else begin
						new_cnt = cur_cnt + COUNT_WIDTH'(1);
					end
				end
				wout_d = new_word;
			end
			rcst_pkg::MODE_RETAIN: begin
				if (!empty) begin
					found_d = 1'b1;
					wout_d  = cur_word;
					if (at_max) begin
						status_d = rcst_pkg::STAT_SATURATED;
					end else begin
						new_cnt = cur_cnt + COUNT_WIDTH'(1);
					end
				end
			end
			rcst_pkg::MODE_RELEASE: begin
				if (empty) begin
					status_d = rcst_pkg::STAT_UNDERFLOW;
				end else begin
					new_cnt = cur_cnt - COUNT_WIDTH'(1);
					if (cur_cnt == COUNT_WIDTH'(1)) begin
						freed_d = 1'b1;
						wout_d  = cur_word;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign cnt_we = advance && in_range_s1;

	always_comb begin
		wout_ext = (DATA_WIDTH + rcst_pkg::WORD_W)'(wout_d);
		cnt_ext  = (COUNT_WIDTH + rcst_pkg::COUNT_W)'(new_cnt);
		if (in_range_s1) begin
			rsp_d.found         = found_d;
			rsp_d.word_out      = wout_ext[rcst_pkg::WORD_W-1:0];
			rsp_d.count_after   = cnt_ext[rcst_pkg::COUNT_W-1:0];
			rsp_d.discarded_new = disc_d;
			rsp_d.freed         = freed_d;
			rsp_d.status        = status_d;
		end else begin
			rsp_d = '0;
		end
	end

	// memories: synchronous read on accept, write back from stage 1 or the clearing pass
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			cnt_mem[clr_q] <= '0;
		end else if (cnt_we) begin
			cnt_mem[s1_slot_ext[IW-1:0]] <= new_cnt;
		end
		if (cnt_we && word_we) begin
			word_mem[s1_slot_ext[IW-1:0]] <= new_word;
		end
		if (accept) begin
			cnt_rd_s1  <= cnt_mem[req_slot_ext[IW-1:0]];
			word_rd_s1 <= word_mem[req_slot_ext[IW-1:0]];
		end
	end

	// stage 1 payload and forwarding values
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1      <= req;
			fwd_cnt_s1  <= new_cnt;
			fwd_word_s1 <= new_word;
		end
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_q       <= '0;
			s1_valid_q  <= 1'b0;
			fwd_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_q <= clr_q + IW'(1);
				if (clr_q == IW'(SLOTS - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
				fwd_s1     <= cnt_we && (req.slot == req_s1.slot);
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[sim/refcount_slot_table_tb.sv]
// ----------------------------------------------------------------------------
// refcount_slot_table_tb
// Drives set, retain, release and unused-mode words into the slot table with
// random gaps and output stalls, and checks every result word field by field
// against an in-order queue filled from literal expected rows or a behavioral copy of the table.
// ----------------------------------------------------------------------------
module refcount_slot_table_tb;

	// mode 3 has no code in the package; the table must leave the slot alone
	localparam logic [rcst_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 1530;

	typedef logic [rcst_pkg::COUNT_W-1:0] cnt_t;
	typedef logic [rcst_pkg::SLOT_W-1:0]  slot_t;

	typedef struct {
		rcst_pkg::req_word_t rq;
		int                  reps;
		bit                  lit;
		rcst_pkg::rsp_word_t want;
	} step_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	rcst_pkg::req_word_t req       = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	rcst_pkg::rsp_word_t rsp;

	cnt_t                           slot_cnt [256];
	logic [rcst_pkg::WORD_W-1:0]    slot_val [256];
	rcst_pkg::rsp_word_t            expected_rsp [$];
	step_t                          plan [$];
	int                             mismatches = 0;
	int                             stall_left = 0;
	bit                             calm       = 1'b0;

	refcount_slot_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #10 clk = ~clk;

	// mostly short idle stretches, now and then a long one
	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 30);
		return $urandom_range(1, 3);
	endfunction

	// updates the table copy and returns the result word the request yields
	function automatic rcst_pkg::rsp_word_t apply_req(rcst_pkg::req_word_t r);
		rcst_pkg::rsp_word_t o;
		cnt_t                c;
		o = '0;
		c = slot_cnt[r.slot];
		case (r.mode)
			rcst_pkg::MODE_SET: begin
				if (c == '0) begin
					slot_val[r.slot] = r.entry_data;
					c = cnt_t'(1);
				end else begin
					o.discarded_new = 1'b1;
					if (c == '1)
						o.status = rcst_pkg::STAT_SATURATED;
					else
						c = c + cnt_t'(1);
				end
				o.found    = 1'b1;
				o.word_out = slot_val[r.slot];
			end
			rcst_pkg::MODE_RETAIN: begin
				if (c != '0) begin
					if (c == '1)
						o.status = rcst_pkg::STAT_SATURATED;
					else
						c = c + cnt_t'(1);
					o.found    = 1'b1;
					o.word_out = slot_val[r.slot];
				end
			end
			rcst_pkg::MODE_RELEASE: begin
				if (c == '0) begin
					o.status = rcst_pkg::STAT_UNDERFLOW;
				end else begin
					c = c - cnt_t'(1);
					if (c == '0) begin
						o.freed    = 1'b1;
						o.word_out = slot_val[r.slot];
					end
				end
			end
			default: begin
			end
		endcase
		slot_cnt[r.slot] = c;
		o.count_after    = c;
		return o;
	endfunction

	function automatic step_t row(logic [rcst_pkg::MODE_W-1:0] m,
			logic [rcst_pkg::SLOT_W-1:0] s, logic [rcst_pkg::WORD_W-1:0] d, int n,
			bit lit, logic f, logic [rcst_pkg::WORD_W-1:0] w, cnt_t c, logic dn,
			logic fr, logic [rcst_pkg::STAT_W-1:0] st);
		step_t t;
		t.rq   = '{mode: m, slot: s, entry_data: d};
		t.reps = n;
		t.lit  = lit;
		t.want = '{found: f, word_out: w, count_after: c, discarded_new: dn,
			freed: fr, status: st};
		return t;
	endfunction

	function automatic string rsp_str(rcst_pkg::rsp_word_t r);
		return $sformatf("found %0d word %h count %0d disc %0d freed %0d status %0d",
			r.found, r.word_out, r.count_after, r.discarded_new, r.freed, r.status);
	endfunction

	// the table copy is updated at the edge where the word is taken
	task automatic push_req(input rcst_pkg::req_word_t w, input bit lit,
			input rcst_pkg::rsp_word_t lit_rsp);
		rcst_pkg::rsp_word_t p;
		int                  gap;
		gap = (calm || $urandom_range(0, 1) == 0) ? 0 : gap_len();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		p = apply_req(w);
		expected_rsp.push_back(lit ? lit_rsp : p);
		if ($urandom_range(0, 199) == 0)
			calm <= ~calm;
	endtask

	// output stalls, single assignment per edge
	always @(posedge clk) begin : rsp_idle
		int n;
		n = stall_left;
		if (n == 0 && !calm && $urandom_range(0, 3) == 0)
			n = gap_len();
		rsp_stall  <= (n != 0);
		stall_left <= (n != 0) ? n - 1 : 0;
	end

	always @(posedge clk) begin : rsp_check
		rcst_pkg::rsp_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: %s", rsp_str(rsp));
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.found !== want.found || rsp.word_out !== want.word_out ||
						rsp.count_after !== want.count_after ||
						rsp.discarded_new !== want.discarded_new ||
						rsp.freed !== want.freed || rsp.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %s / actual %s",
							rsp_str(want), rsp_str(rsp));
				end
			end
		end
	end

	initial begin
		rcst_pkg::req_word_t r;
		int                  k;
		int                  x;
		for (k = 0; k < 256; k++) begin
			slot_cnt[k] = '0;
			slot_val[k] = '0;
		end

		//              mode          slot   data          reps   lit found word
		//                                                        count   disc freed status
		plan.push_back(row(rcst_pkg::MODE_RETAIN,  8'd0,   32'h0000_0000, 1, 1'b1, 1'b0,
			32'h0000_0000, 16'd0, 1'b0, 1'b0, rcst_pkg::STAT_OK));
		plan.push_back(row(rcst_pkg::MODE_RELEASE, 8'd255, 32'h0000_0000, 1, 1'b1, 1'b0,
			32'h0000_0000, 16'd0, 1'b0, 1'b0, rcst_pkg::STAT_UNDERFLOW));
		plan.push_back(row(MODE_UNUSED,            8'd7,   32'hffff_ffff, 1, 1'b1, 1'b0,
			32'h0000_0000, 16'd0, 1'b0, 1'b0, rcst_pkg::STAT_OK));
		plan.push_back(row(rcst_pkg::MODE_SET,     8'd0,   32'h0000_0000, 1, 1'b1, 1'b1,
			32'h0000_0000, 16'd1, 1'b0, 1'b0, rcst_pkg::STAT_OK));
		plan.push_back(row(rcst_pkg::MODE_SET,     8'd255, 32'hffff_ffff, 1, 1'b1, 1'b1,
			32'hffff_ffff, 16'd1, 1'b0, 1'b0, rcst_pkg::STAT_OK));
		plan.push_back(row(rcst_pkg::MODE_SET,     8'd255, 32'h1234_5678, 1, 1'b1, 1'b1,
			32'hffff_ffff, 16'd2, 1'b1, 1'b0, rcst_pkg::STAT_OK));
		plan.push_back(row(rcst_pkg::MODE_RETAIN,  8'd255, 32'h0000_0000, 1, 1'b1, 1'b1,
			32'hffff_ffff, 16'd3, 1'b0, 1'b0, rcst_pkg::STAT_OK));
		plan.push_back(row(MODE_UNUSED,            8'd255, 32'h0000_0000, 1, 1'b1, 1'b0,
			32'h0000_0000, 16'd3, 1'b0, 1'b0, rcst_pkg::STAT_OK));
		plan.push_back(row(rcst_pkg::MODE_RELEASE, 8'd255, 32'h0000_0000, 2, 1'b0, 1'b0,
			32'h0, 16'd0, 1'b0, 1'b0, rcst_pkg::STAT_OK));
		plan.push_back(row(rcst_pkg::MODE_RELEASE, 8'd255, 32'h0000_0000, 1, 1'b1, 1'b0,
			32'hffff_ffff, 16'd0, 1'b0, 1'b1, rcst_pkg::STAT_OK));
		plan.push_back(row(rcst_pkg::MODE_RELEASE, 8'd255, 32'h0000_0000, 1, 1'b1, 1'b0,
			32'h0000_0000, 16'd0, 1'b0, 1'b0, rcst_pkg::STAT_UNDERFLOW));
		plan.push_back(row(rcst_pkg::MODE_SET,     8'd128, 32'ha5a5_5a5a, 1, 1'b0, 1'b0,
			32'h0, 16'd0, 1'b0, 1'b0, rcst_pkg::STAT_OK));
		plan.push_back(row(rcst_pkg::MODE_RETAIN,  8'd128, 32'h0000_0000, 1, 1'b1, 1'b1,
			32'ha5a5_5a5a, 16'd2, 1'b0, 1'b0, rcst_pkg::STAT_OK));
		plan.push_back(row(rcst_pkg::MODE_RELEASE, 8'd128, 32'h0000_0000, 1, 1'b1, 1'b0,
			32'h0000_0000, 16'd1, 1'b0, 1'b0, rcst_pkg::STAT_OK));
		plan.push_back(row(rcst_pkg::MODE_SET,     8'd1,   32'h8000_0001, 1, 1'b0, 1'b0,
			32'h0, 16'd0, 1'b0, 1'b0, rcst_pkg::STAT_OK));
		plan.push_back(row(rcst_pkg::MODE_RELEASE, 8'd1,   32'h0000_0000, 1, 1'b0, 1'b0,
			32'h0, 16'd0, 1'b0, 1'b0, rcst_pkg::STAT_OK));
		plan.push_back(row(rcst_pkg::MODE_SET,     8'd1,   32'h7fff_fffe, 1, 1'b0, 1'b0,
			32'h0, 16'd0, 1'b0, 1'b0, rcst_pkg::STAT_OK));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			for (k = 0; k < plan[i].reps; k++)
				push_req(plan[i].rq, plan[i].lit, plan[i].want);

		// most words land on a few hot slots so counts climb and free
		for (k = 0; k < RANDOM_WORDS; k++) begin
			x = $urandom_range(0, 19);
			if (x < 7)
				r.mode = rcst_pkg::MODE_SET;
			else if (x < 12)
				r.mode = rcst_pkg::MODE_RETAIN;
			else if (x < 19)
				r.mode = rcst_pkg::MODE_RELEASE;
			else
				r.mode = MODE_UNUSED;
			if ($urandom_range(0, 9) < 7)
				r.slot = slot_t'($urandom_range(0, 7));
			else
				r.slot = slot_t'($urandom_range(0, 255));
			case ($urandom_range(0, 7))
				0: r.entry_data = '0;
				1: r.entry_data = '1;
				default: r.entry_data = $urandom;
			endcase
			push_req(r, 1'b0, '0);
		end
		req_valid <= 1'b0;

		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_rsp.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#20000000;
		$display("FAILURE");
		$finish;
	end

endmodule
